### rtl/fugc_pkg.sv
// shared types, constants and character tables for the framed utf-16 group checksum
// no dependencies
`default_nettype none

package fugc_pkg;

  localparam logic [31:0] HASH_MUL = 32'h006f_4f53;
  localparam logic [31:0] HASH_ADD = 32'h0000_0b7f;
  localparam logic [31:0] HASH_INIT = 32'h0000_0001;

  localparam logic [3:0] OPEN_LEN = 4'd8;
  localparam logic [3:0] CLOSE_LEN = 4'd10;

  localparam logic [1:0] PH_SEEK_OPEN = 2'd0;
  localparam logic [1:0] PH_SEEK_GT = 2'd1;
  localparam logic [1:0] PH_BODY = 2'd2;
  localparam logic [1:0] PH_DONE = 2'd3;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_NO_MARK = 2'd1;
  localparam logic [1:0] ST_BAD_UTF8 = 2'd2;

  localparam logic [7:0] CH_LT = 8'h3c;
  localparam logic [7:0] CH_GT = 8'h3e;
  localparam logic [7:0] CH_SLASH = 8'h2f;
  localparam logic [7:0] CH_B = 8'h62;
  localparam logic [7:0] CH_O = 8'h6f;
  localparam logic [7:0] CH_L = 8'h6c;
  localparam logic [7:0] CH_K = 8'h6b;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_SCAN,
    OP_REPLAY,
    OP_DECODE,
    OP_UNIT_HI,
    OP_UNIT_LO,
    OP_UNIT_BMP,
    OP_FOLD_A,
    OP_FOLD_B,
    OP_OUT
  } fugc_op_e;

  typedef enum logic [1:0] {
    EMIT_NONE,
    EMIT_BMP,
    EMIT_PAIR
  } fugc_emit_e;

  typedef struct packed {
    fugc_op_e op;
  } fugc_cmd_t;

  typedef struct packed {
    logic       body_miss;
    logic       mp_zero;
    logic       replay_last;
    logic       unit_fills;
    logic       final_fold;
    logic       out_busy;
    logic       last;
    fugc_emit_e emit;
  } fugc_stat_t;

  function automatic logic [7:0] open_char(input logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0: c = CH_LT;
      3'd1: c = CH_B;
      3'd2: c = CH_O;
      3'd3: c = CH_L;
      3'd4: c = CH_L;
      3'd5: c = CH_B;
      3'd6: c = CH_O;
      default: c = CH_K;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] close_char(input logic [3:0] idx);
    logic [7:0] c;
    case (idx)
      4'd0: c = CH_LT;
      4'd1: c = CH_SLASH;
      4'd2: c = CH_B;
      4'd3: c = CH_O;
      4'd4: c = CH_L;
      4'd5: c = CH_L;
      4'd6: c = CH_B;
      4'd7: c = CH_O;
      4'd8: c = CH_K;
      4'd9: c = CH_GT;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

### rtl/fugc_if.sv
// valid/ready channel interfaces for document bytes and checksum results
// no dependencies
`default_nettype none

interface fugc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] doc_byte;
  logic       last;

  modport source (output valid, output doc_byte, output last, input ready);
  modport sink (input valid, input doc_byte, input last, output ready);
endinterface

interface fugc_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] checksum;
  logic [1:0]  status;

  modport source (output valid, output checksum, output status, input ready);
  modport sink (input valid, input checksum, input status, output ready);
endinterface

`default_nettype wire

### rtl/framed_utf16_group_checksum_core.sv
// top level of the framed utf-16 group checksum: controller plus datapath
// depends on fugc_pkg, fugc_if, fugc_ctrl, fugc_dpath
//
// channel      dir  payload                 beat
// in_chan_i    in   doc_byte[7:0], last     one document byte
// out_chan_o   out  checksum[31:0], status  one result, after the last byte
//
// a byte is loaded and scanned; a body byte outside the closing tag replays any held
// marker bytes, then is decoded, and one that ends a code point adds a unit or a pair;
// each full group folds into the hash through an adder, then a multiplier
// the last byte loads the result register, after any partial group folds
// reset is asynchronous and returns to seeking the opening tag with the hash at one
// a stalled result holds the block only at the next last byte
`default_nettype none

module framed_utf16_group_checksum_core #(
  parameter int unsigned GROUP_SIZE = 8
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  fugc_in_if.sink    in_chan_i,
  fugc_out_if.source out_chan_o
);
  import fugc_pkg::*;

  fugc_cmd_t  cmd;
  fugc_stat_t stat;
  logic       in_ready;

  fugc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_chan_i.valid),
    .in_ready_o (in_ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  fugc_dpath #(
    .GROUP_SIZE (GROUP_SIZE)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .doc_byte_i  (in_chan_i.doc_byte),
    .last_i      (in_chan_i.last),
    .out_ready_i (out_chan_o.ready),
    .out_valid_o (out_chan_o.valid),
    .checksum_o  (out_chan_o.checksum),
    .status_o    (out_chan_o.status)
  );

  assign in_chan_i.ready = in_ready;

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_chan_i.valid && in_chan_i.ready) |=> !in_chan_i.ready)
    else $error("input accepted on back to back cycles");

  a_result_needs_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_chan_o.valid) |-> !$past(in_chan_i.ready))
    else $error("result appeared while block was idle");

  a_error_zero_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_chan_o.valid && out_chan_o.status != ST_OK) |-> out_chan_o.checksum == 32'h0)
    else $error("nonzero checksum with error status");

endmodule

`default_nettype wire

### rtl/fugc_ctrl.sv
// controller state machine: sequences scan, replay, decode, unit and fold steps per byte
// depends on fugc_pkg
`default_nettype none

module fugc_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  fugc_pkg::fugc_stat_t stat_i,
  output fugc_pkg::fugc_cmd_t  cmd_o
);
  import fugc_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_SCAN = 4'd1;
  localparam logic [3:0] S_REPLAY = 4'd2;
  localparam logic [3:0] S_DECODE = 4'd3;
  localparam logic [3:0] S_UNIT_HI = 4'd4;
  localparam logic [3:0] S_UNIT_LO = 4'd5;
  localparam logic [3:0] S_UNIT_BMP = 4'd6;
  localparam logic [3:0] S_FOLD_A = 4'd7;
  localparam logic [3:0] S_FOLD_B = 4'd8;
  localparam logic [3:0] S_END = 4'd9;
  localparam logic [3:0] S_FINAL = 4'd10;

  logic [3:0] state_q, state_d;
  logic [3:0] ret_q, ret_d;
  logic [3:0] nxt;

  always_comb begin
    state_d = state_q;
    ret_d = ret_q;
    cmd_o.op = OP_NONE;
    in_ready_o = 1'b0;
    nxt = S_END;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.op = OP_LOAD;
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd_o.op = OP_SCAN;
        if (stat_i.body_miss) begin
          state_d = stat_i.mp_zero ? S_DECODE : S_REPLAY;
        end else begin
          state_d = S_END;
        end
      end
      S_REPLAY: begin
        cmd_o.op = OP_REPLAY;
        nxt = stat_i.replay_last ? S_DECODE : S_REPLAY;
      end
      S_DECODE: begin
        cmd_o.op = OP_DECODE;
        case (stat_i.emit)
          EMIT_BMP: state_d = S_UNIT_BMP;
          EMIT_PAIR: state_d = S_UNIT_HI;
          default: state_d = S_END;
        endcase
      end
      S_UNIT_HI: begin
        cmd_o.op = OP_UNIT_HI;
        nxt = S_UNIT_LO;
      end
      S_UNIT_LO: begin
        cmd_o.op = OP_UNIT_LO;
        nxt = S_END;
      end
      S_UNIT_BMP: begin
        cmd_o.op = OP_UNIT_BMP;
        nxt = S_END;
      end
      S_FOLD_A: begin
        cmd_o.op = OP_FOLD_A;
        state_d = S_FOLD_B;
      end
      S_FOLD_B: begin
        cmd_o.op = OP_FOLD_B;
        state_d = ret_q;
      end
      S_END: begin
        if (!stat_i.last) begin
          state_d = S_IDLE;
        end else if (stat_i.final_fold) begin
          state_d = S_FOLD_A;
          ret_d = S_FINAL;
        end else begin
          state_d = S_FINAL;
        end
      end
      S_FINAL: begin
        if (!stat_i.out_busy) begin
          cmd_o.op = OP_OUT;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    // every unit step folds a full group before moving on
    if (state_q == S_REPLAY || state_q == S_UNIT_HI || state_q == S_UNIT_LO ||
        state_q == S_UNIT_BMP) begin
      if (stat_i.unit_fills) begin
        state_d = S_FOLD_A;
        ret_d = nxt;
      end else begin
        state_d = nxt;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ret_q <= S_IDLE;
    end else begin
      state_q <= state_d;
      ret_q <= ret_d;
    end
  end

endmodule

`default_nettype wire

### rtl/fugc_dpath.sv
// datapath: marker matching, utf-8 decode, group adder, hash fold and result register
// depends on fugc_pkg
`default_nettype none

module fugc_dpath #(
  parameter int unsigned GROUP_SIZE = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  fugc_pkg::fugc_cmd_t  cmd_i,
  output fugc_pkg::fugc_stat_t stat_o,
  input  logic [7:0]           doc_byte_i,
  input  logic                 last_i,
  input  logic                 out_ready_i,
  output logic                 out_valid_o,
  output logic [31:0]          checksum_o,
  output logic [1:0]           status_o
);
  import fugc_pkg::*;

  localparam int unsigned CNT_W = $clog2(GROUP_SIZE + 1);
  localparam int unsigned SUM_W = 16 + $clog2(GROUP_SIZE);

  logic [7:0]       byte_q, byte_d;
  logic             last_q, last_d;
  logic [1:0]       phase_q, phase_d;
  logic [3:0]       mp_q, mp_d;
  logic [3:0]       ri_q, ri_d;
  logic [31:0]      hash_q, hash_d;
  logic [31:0]      pre_q, pre_d;
  logic [SUM_W-1:0] sum_q, sum_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [20:0]      cp_q, cp_d;
  logic [1:0]       rem_q, rem_d;
  logic             err_q, err_d;
  logic             out_valid_q, out_valid_d;
  logic [31:0]      out_sum_q, out_sum_d;
  logic [1:0]       out_st_q, out_st_d;

  logic             open_hit;
  logic             close_hit;
  logic             add_unit;
  logic [15:0]      unit;
  logic [20:0]      sup;
  logic [20:0]      cp_n;
  logic [20:0]      pt;
  logic             pt_valid;
  fugc_emit_e       emit;

  assign open_hit = (byte_q == open_char(mp_q[2:0]));
  assign close_hit = (byte_q == close_char(mp_q));
  assign sup = cp_q - 21'h010000;

  always_comb begin
    byte_d = byte_q;
    last_d = last_q;
    phase_d = phase_q;
    mp_d = mp_q;
    ri_d = ri_q;
    hash_d = hash_q;
    pre_d = pre_q;
    sum_d = sum_q;
    cnt_d = cnt_q;
    cp_d = cp_q;
    rem_d = rem_q;
    err_d = err_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    out_sum_d = out_sum_q;
    out_st_d = out_st_q;
    add_unit = 1'b0;
    unit = 16'h0000;
    cp_n = {cp_q[14:0], byte_q[5:0]};
    pt = 21'h0;
    pt_valid = 1'b0;
    emit = EMIT_NONE;

    unique case (cmd_i.op)
      OP_LOAD: begin
        byte_d = doc_byte_i;
        last_d = last_i;
      end
      OP_SCAN: begin
        case (phase_q)
          PH_SEEK_OPEN: begin
            if (open_hit) begin
              if (mp_q == OPEN_LEN - 4'd1) begin
                phase_d = PH_SEEK_GT;
                mp_d = 4'd0;
              end else begin
                mp_d = mp_q + 4'd1;
              end
            end else begin
              mp_d = (byte_q == CH_LT) ? 4'd1 : 4'd0;
            end
          end
          PH_SEEK_GT: begin
            if (byte_q == CH_GT) begin
              phase_d = PH_BODY;
            end
          end
          PH_BODY: begin
            if (close_hit) begin
              if (mp_q == 4'd0 && rem_q != 2'd0) begin
                err_d = 1'b1;
                rem_d = 2'd0;
              end
              if (mp_q == CLOSE_LEN - 4'd1) begin
                phase_d = PH_DONE;
                mp_d = 4'd0;
              end else begin
                mp_d = mp_q + 4'd1;
              end
            end else begin
              ri_d = 4'd0;
            end
          end
          default: ;
        endcase
      end
      OP_REPLAY: begin
        add_unit = 1'b1;
        unit = {8'h00, close_char(ri_q)};
        ri_d = ri_q + 4'd1;
      end
      OP_DECODE: begin
        if (byte_q == CH_LT) begin
          if (rem_q != 2'd0) begin
            err_d = 1'b1;
          end
          rem_d = 2'd0;
          mp_d = 4'd1;
        end else begin
          mp_d = 4'd0;
          if (rem_q != 2'd0 && byte_q[7:6] == 2'b10) begin
            cp_d = cp_n;
            rem_d = rem_q - 2'd1;
            if (rem_q == 2'd1) begin
              pt_valid = 1'b1;
              pt = cp_n;
            end
          end else begin
            if (rem_q != 2'd0) begin
              err_d = 1'b1;
            end
            rem_d = 2'd0;
            if (!byte_q[7]) begin
              pt_valid = 1'b1;
              pt = {13'h0, byte_q};
              cp_d = {13'h0, byte_q};
            end else if (byte_q[7:5] == 3'b110) begin
              cp_d = {16'h0, byte_q[4:0]};
              rem_d = 2'd1;
            end else if (byte_q[7:4] == 4'b1110) begin
              cp_d = {17'h0, byte_q[3:0]};
              rem_d = 2'd2;
            end else if (byte_q[7:3] == 5'b11110) begin
              cp_d = {18'h0, byte_q[2:0]};
              rem_d = 2'd3;
            end else begin
              err_d = 1'b1;
            end
          end
          if (pt_valid) begin
            if (pt > 21'h10ffff || (pt >= 21'h00d800 && pt <= 21'h00dfff)) begin
              err_d = 1'b1;
            end else if (pt >= 21'h010000) begin
              emit = EMIT_PAIR;
            end else begin
              emit = EMIT_BMP;
            end
          end
        end
      end
      OP_UNIT_HI: begin
        add_unit = 1'b1;
        unit = 16'hd800 + {6'h00, sup[19:10]};
      end
      OP_UNIT_LO: begin
        add_unit = 1'b1;
        unit = 16'hdc00 + {6'h00, sup[9:0]};
      end
      OP_UNIT_BMP: begin
        add_unit = 1'b1;
        unit = cp_q[15:0];
      end
      OP_FOLD_A: begin
        pre_d = hash_q + 32'(sum_q);
      end
      OP_FOLD_B: begin
        hash_d = pre_q * HASH_MUL + HASH_ADD;
        sum_d = '0;
        cnt_d = '0;
      end
      OP_OUT: begin
        out_valid_d = 1'b1;
        if (phase_q != PH_DONE) begin
          out_st_d = ST_NO_MARK;
          out_sum_d = 32'h0;
        end else if (err_q) begin
          out_st_d = ST_BAD_UTF8;
          out_sum_d = 32'h0;
        end else begin
          out_st_d = ST_OK;
          out_sum_d = hash_q;
        end
        phase_d = PH_SEEK_OPEN;
        mp_d = 4'd0;
        hash_d = HASH_INIT;
        sum_d = '0;
        cnt_d = '0;
        cp_d = 21'h0;
        rem_d = 2'd0;
        err_d = 1'b0;
      end
      default: ;
    endcase

    if (add_unit) begin
      sum_d = sum_q + SUM_W'(unit);
      cnt_d = cnt_q + CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_SEEK_OPEN;
      mp_q <= 4'd0;
      ri_q <= 4'd0;
      hash_q <= HASH_INIT;
      sum_q <= '0;
      cnt_q <= '0;
      cp_q <= 21'h0;
      rem_q <= 2'd0;
      err_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q <= phase_d;
      mp_q <= mp_d;
      ri_q <= ri_d;
      hash_q <= hash_d;
      sum_q <= sum_d;
      cnt_q <= cnt_d;
      cp_q <= cp_d;
      rem_q <= rem_d;
      err_q <= err_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
    last_q <= last_d;
    pre_q <= pre_d;
    out_sum_q <= out_sum_d;
    out_st_q <= out_st_d;
  end

  assign stat_o.body_miss = (phase_q == PH_BODY) && !close_hit;
  assign stat_o.mp_zero = (mp_q == 4'd0);
  assign stat_o.replay_last = (ri_q == mp_q - 4'd1);
  assign stat_o.unit_fills = (cnt_q == CNT_W'(GROUP_SIZE - 1));
  assign stat_o.final_fold = (phase_q == PH_DONE) && !err_q && (cnt_q != '0);
  assign stat_o.out_busy = out_valid_q && !out_ready_i;
  assign stat_o.last = last_q;
  assign stat_o.emit = emit;

  assign out_valid_o = out_valid_q;
  assign checksum_o = out_sum_q;
  assign status_o = out_st_q;

endmodule

`default_nettype wire

### bench/framed_utf16_group_checksum_core_test.sv
// self-checking bench for framed_utf16_group_checksum_core: directed and random documents
// fed byte by byte, each result predicted in a scoreboard class, random stalls on both sides
// depends on fugc_pkg, fugc_if and the core rtl

module framed_utf16_group_checksum_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import fugc_pkg::*;

  localparam int unsigned GROUP_SIZE = 8;
  localparam int unsigned RANDOM_BYTES = 1000;
  localparam int unsigned MIN_DOCS = 20;
  localparam int unsigned DRAIN_CYCLES = 64;

  localparam logic [0:7][7:0] OPEN_TAG = {CH_LT, CH_B, CH_O, CH_L, CH_L, CH_B, CH_O, CH_K};
  localparam logic [0:9][7:0] CLOSE_TAG = {
    CH_LT, CH_SLASH, CH_B, CH_O, CH_L, CH_L, CH_B, CH_O, CH_K, CH_GT
  };

  typedef struct packed {
    logic [31:0] checksum;
    logic [1:0]  status;
  } verdict_t;

  class checksum_board;
    verdict_t    owed[$];
    int unsigned errors;
    logic [1:0]  phase;
    int unsigned mark_pos;
    logic [31:0] hash;
    logic [18:0] unit_sum;
    int unsigned unit_cnt;
    logic [20:0] point;
    int unsigned cont_left;
    bit          bad_utf8;

    function new();
      errors = 0;
      restart();
    endfunction

    function void restart();
      phase = PH_SEEK_OPEN;
      mark_pos = 0;
      hash = HASH_INIT;
      unit_sum = '0;
      unit_cnt = 0;
      point = '0;
      cont_left = 0;
      bad_utf8 = 1'b0;
    endfunction

    function void add_unit(logic [15:0] unit);
      unit_sum = unit_sum + unit;
      unit_cnt++;
      if (unit_cnt >= GROUP_SIZE) begin
        hash = (hash + unit_sum) * HASH_MUL + HASH_ADD;
        unit_sum = '0;
        unit_cnt = 0;
      end
    endfunction

    function void put_point(logic [20:0] cp);
      logic [20:0] offs;
      if (cp > 21'h10ffff || (cp >= 21'h00d800 && cp <= 21'h00dfff)) begin
        bad_utf8 = 1'b1;
      end else if (cp >= 21'h010000) begin
        offs = cp - 21'h010000;
        add_unit(16'hd800 + {6'd0, offs[19:10]});
        add_unit(16'hdc00 + {6'd0, offs[9:0]});
      end else begin
        add_unit(cp[15:0]);
      end
    endfunction

    function void decode(logic [7:0] b);
      if (cont_left != 0) begin
        if (b[7:6] == 2'b10) begin
          point = {point[14:0], b[5:0]};
          cont_left--;
          if (cont_left == 0) put_point(point);
          return;
        end
        bad_utf8 = 1'b1;
        cont_left = 0;
      end
      if (b < 8'h80) begin
        put_point({13'd0, b});
      end else if (b >= 8'hc0 && b <= 8'hdf) begin
        point = {16'd0, b[4:0]};
        cont_left = 1;
      end else if (b >= 8'he0 && b <= 8'hef) begin
        point = {17'd0, b[3:0]};
        cont_left = 2;
      end else if (b >= 8'hf0 && b <= 8'hf7) begin
        point = {18'd0, b[2:0]};
        cont_left = 3;
      end else begin
        bad_utf8 = 1'b1;
      end
    endfunction

    function void body_byte(logic [7:0] b);
      if (mark_pos < CLOSE_LEN && b == CLOSE_TAG[mark_pos]) begin
        if (mark_pos == 0 && cont_left != 0) begin
          bad_utf8 = 1'b1;
          cont_left = 0;
        end
        mark_pos++;
        if (mark_pos >= CLOSE_LEN) begin
          phase = PH_DONE;
          mark_pos = 0;
        end
        return;
      end
      // held tag bytes count as text, then the breaking byte starts over
      for (int i = 0; i < mark_pos; i++) add_unit({8'd0, CLOSE_TAG[i]});
      mark_pos = 0;
      if (b == CH_LT) begin
        if (cont_left != 0) begin
          bad_utf8 = 1'b1;
          cont_left = 0;
        end
        mark_pos = 1;
      end else begin
        decode(b);
      end
    endfunction

    function void note_byte(logic [7:0] b, logic lst);
      verdict_t v;
      case (phase)
        PH_SEEK_OPEN: begin
          if (b == OPEN_TAG[mark_pos]) mark_pos++;
          else mark_pos = (b == CH_LT) ? 1 : 0;
          if (mark_pos >= OPEN_LEN) begin
            phase = PH_SEEK_GT;
            mark_pos = 0;
          end
        end
        PH_SEEK_GT: begin
          if (b == CH_GT) phase = PH_BODY;
        end
        PH_BODY: begin
          body_byte(b);
        end
        default: ;
      endcase
      if (!lst) return;
      v.checksum = '0;
      if (phase != PH_DONE) begin
        v.status = ST_NO_MARK;
      end else if (bad_utf8) begin
        v.status = ST_BAD_UTF8;
      end else begin
        v.status = ST_OK;
        v.checksum = hash;
        if (unit_cnt != 0) v.checksum = (hash + unit_sum) * HASH_MUL + HASH_ADD;
      end
      owed.push_back(v);
      restart();
    endfunction

    task report(string what);
      $display("%0t: mismatch: %s", $time, what);
      errors++;
    endtask

    task check_result(logic [31:0] sum, logic [1:0] st);
      verdict_t want;
      if (owed.size() == 0) begin
        report($sformatf("result with no document pending, checksum %h status %0d", sum, st));
        return;
      end
      want = owed.pop_front();
      if (sum !== want.checksum)
        report($sformatf("checksum %h, expected %h", sum, want.checksum));
      if (st !== want.status)
        report($sformatf("status %0d, expected %0d", st, want.status));
    endtask
  endclass

  logic clk_i;
  logic rst_ni;

  fugc_in_if  in_chan ();
  fugc_out_if out_chan ();

  framed_utf16_group_checksum_core #(
    .GROUP_SIZE(GROUP_SIZE)
  ) u_dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_chan_i (in_chan),
    .out_chan_o(out_chan)
  );

  checksum_board board = new();

  logic [7:0]  doc_q[$];
  int unsigned bytes_sent;
  int unsigned docs_sent;

  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  function automatic void push_tag(bit closing, int unsigned n);
    for (int i = 0; i < n; i++) doc_q.push_back(closing ? CLOSE_TAG[i] : OPEN_TAG[i]);
  endfunction

  function automatic void push_point(logic [20:0] cp);
    if (cp < 21'h80) begin
      doc_q.push_back({1'b0, cp[6:0]});
    end else if (cp < 21'h800) begin
      doc_q.push_back({3'b110, cp[10:6]});
      doc_q.push_back({2'b10, cp[5:0]});
    end else if (cp < 21'h10000) begin
      doc_q.push_back({4'b1110, cp[15:12]});
      doc_q.push_back({2'b10, cp[11:6]});
      doc_q.push_back({2'b10, cp[5:0]});
    end else begin
      doc_q.push_back({5'b11110, cp[20:18]});
      doc_q.push_back({2'b10, cp[17:12]});
      doc_q.push_back({2'b10, cp[11:6]});
      doc_q.push_back({2'b10, cp[5:0]});
    end
  endfunction

  function automatic void push_token(bit broken);
    logic [20:0] cp;
    int unsigned k;
    if (broken) begin
      case ($urandom_range(0, 5))
        0: doc_q.push_back(8'($urandom_range(8'h80, 8'hbf)));
        1: doc_q.push_back(8'($urandom_range(8'hf8, 8'hff)));
        2: begin
          // sequence cut short by a plain byte
          doc_q.push_back(8'($urandom_range(8'hc0, 8'hf7)));
          doc_q.push_back(8'($urandom_range(0, 8'h7f)));
        end
        3: begin
          doc_q.push_back(8'hed);
          doc_q.push_back(8'($urandom_range(8'ha0, 8'hbf)));
          doc_q.push_back(8'($urandom_range(8'h80, 8'hbf)));
        end
        4: begin
          doc_q.push_back(8'($urandom_range(8'hf4, 8'hf7)));
          doc_q.push_back(8'($urandom_range(8'h90, 8'hbf)));
          doc_q.push_back(8'($urandom_range(8'h80, 8'hbf)));
          doc_q.push_back(8'($urandom_range(8'h80, 8'hbf)));
        end
        default: doc_q.push_back(8'($urandom_range(0, 255)));
      endcase
      return;
    end
    k = $urandom_range(0, 99);
    if (k < 40) begin
      push_point(21'($urandom_range(0, 'h7f)));
    end else if (k < 55) begin
      push_point(21'($urandom_range('h80, 'h7ff)));
    end else if (k < 68) begin
      cp = 21'($urandom_range('h800, 'hffff));
      push_point(cp[15:11] == 5'b11011 ? cp ^ 21'h4000 : cp);
    end else if (k < 80) begin
      push_point(21'($urandom_range('h10000, 'h10ffff)));
    end else if (k < 86) begin
      // overlong two-byte form
      cp = 21'($urandom_range(0, 'h7f));
      doc_q.push_back({6'b110000, cp[7:6]});
      doc_q.push_back({2'b10, cp[5:0]});
    end else if (k < 97) begin
      push_tag(1'b1, $urandom_range(1, CLOSE_LEN - 1));
      push_point(21'($urandom_range(0, 'h7f)));
    end else begin
      doc_q.push_back(CH_LT);
    end
  endfunction

  task automatic send_doc();
    int unsigned gap;
    bit calm;
    calm = ($urandom_range(0, 4) == 0);
    foreach (doc_q[i]) begin
      gap = calm ? 0 : $urandom_range(0, 8);
      if (gap != 0) begin
        in_chan.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      in_chan.valid <= 1'b1;
      in_chan.doc_byte <= doc_q[i];
      in_chan.last <= (i == doc_q.size() - 1);
      do @(posedge clk_i); while (!in_chan.ready);
      board.note_byte(doc_q[i], i == doc_q.size() - 1);
      bytes_sent++;
    end
    doc_q.delete();
    docs_sent++;
  endtask

  initial begin
    int unsigned kind;
    int unsigned n;
    bit dirty;
    logic [7:0] b;

    rst_ni <= 1'b0;
    in_chan.valid <= 1'b0;
    in_chan.doc_byte <= '0;
    in_chan.last <= 1'b0;
    out_chan.ready <= 1'b0;
    bytes_sent = 0;
    docs_sent = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // lone byte, no tag at all
    doc_q.push_back(8'hff);
    send_doc();

    // empty body
    doc_q.push_back(8'h00);
    push_tag(1'b0, OPEN_LEN);
    doc_q.push_back(CH_GT);
    push_tag(1'b1, CLOSE_LEN);
    send_doc();

    // range ends of every encoding length, broken closing tags, trailing byte
    push_tag(1'b0, OPEN_LEN);
    doc_q.push_back(8'h20);
    doc_q.push_back(CH_GT);
    push_point(21'h0);
    push_point(21'h7f);
    push_point(21'h80);
    push_point(21'h7ff);
    push_point(21'h800);
    push_point(21'hffff);
    push_point(21'h10000);
    push_point(21'h10ffff);
    push_tag(1'b1, 3);
    doc_q.push_back(8'h78);
    push_tag(1'b1, CLOSE_LEN - 1);
    doc_q.push_back(CH_LT);
    push_tag(1'b1, CLOSE_LEN);
    doc_q.push_back(8'hff);
    send_doc();

    // sequence cut short by the closing tag
    push_tag(1'b0, OPEN_LEN);
    doc_q.push_back(CH_GT);
    doc_q.push_back(8'he2);
    push_tag(1'b1, CLOSE_LEN);
    send_doc();

    bytes_sent = 0;
    while (bytes_sent < RANDOM_BYTES || docs_sent < MIN_DOCS) begin
      kind = $urandom_range(0, 99);
      if (kind < 6) begin
        repeat ($urandom_range(1, 6)) doc_q.push_back(8'($urandom_range(0, 255)));
      end else begin
        repeat ($urandom_range(0, 2)) doc_q.push_back(8'($urandom_range(0, 255)));
        if ($urandom_range(0, 5) == 0) begin
          push_tag(1'b0, $urandom_range(1, OPEN_LEN - 1));
          doc_q.push_back(8'($urandom_range(0, 255)));
        end
        push_tag(1'b0, OPEN_LEN);
        if (kind < 10)
          doc_q[doc_q.size() - $urandom_range(1, OPEN_LEN)] = 8'($urandom_range(0, 255));
        repeat ($urandom_range(0, 3)) begin
          b = 8'($urandom_range(0, 255));
          doc_q.push_back(b == CH_GT ? CH_LT : b);
        end
        doc_q.push_back(CH_GT);
        dirty = ($urandom_range(0, 3) == 0);
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 60) : $urandom_range(0, 12);
        repeat (n) push_token(dirty && $urandom_range(0, 5) == 0);
        if (dirty && $urandom_range(0, 2) == 0)
          doc_q.push_back(8'($urandom_range(8'hc0, 8'hf7)));
        if (kind >= 14) push_tag(1'b1, CLOSE_LEN);
        if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 3)) push_token(1'b1);
      end
      send_doc();
      // after every eighth document, hold the sender until every result is back
      if (docs_sent % 8 == 0) begin
        in_chan.valid <= 1'b0;
        do @(posedge clk_i); while (board.owed.size() != 0);
      end
    end
    in_chan.valid <= 1'b0;

    while (board.owed.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (board.errors == 0) begin
      $display("framed_utf16_group_checksum_core_test: PASS");
    end else begin
      $display("framed_utf16_group_checksum_core_test: FAIL");
    end
    $finish;
  end

  initial begin
    int unsigned stall;
    int unsigned calm_left;
    calm_left = 0;
    wait (rst_ni === 1'b1);
    forever begin
      if (calm_left != 0) begin
        calm_left--;
        stall = 0;
      end else begin
        stall = $urandom_range(0, 8);
        if ($urandom_range(0, 9) == 0) calm_left = $urandom_range(4, 20);
      end
      if (stall != 0) begin
        out_chan.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_chan.ready <= 1'b1;
      do @(posedge clk_i); while (!out_chan.valid);
      board.check_result(out_chan.checksum, out_chan.status);
    end
  end

  initial begin
    #5_000_000;
    $display("framed_utf16_group_checksum_core_test: FAIL");
    $finish;
  end

endmodule

### files.f
rtl/fugc_pkg.sv
rtl/fugc_if.sv
rtl/fugc_ctrl.sv
rtl/fugc_dpath.sv
rtl/framed_utf16_group_checksum_core.sv
bench/framed_utf16_group_checksum_core_test.sv
